@@ design/ddscf_pkg.sv @@
// Shared types and constants of the synthesizer channel command framer.
package ddscf_pkg;

  localparam int unsigned ValW       = 32;
  localparam int unsigned FreqW      = 29;
  localparam int unsigned CfgW       = 29;
  localparam int unsigned RefClockHz = 500000000;

  // Upper frequency limit after reset, in Hz.
  localparam logic [CfgW-1:0] FreqUpperReset = 29'd200000000;
  localparam logic [CfgW-1:0] FreqLowerReset = 29'd0;

  // Serial register addresses and fixed byte patterns.
  localparam logic [7:0] AddrChanSel  = 8'h00;
  localparam logic [7:0] AddrFreq     = 8'h04;
  localparam logic [7:0] AddrPhase    = 8'h05;
  localparam logic [7:0] AddrAmp      = 8'h06;
  localparam logic [7:0] ChanMaskBase = 8'h10;
  localparam logic [7:0] AmpEnable    = 8'h10;

  // Amplitude scaling: floor(mv * 1024 / 500) = floor((mv << 10) / 500)
  // computed as floor((mv << 8) / 125) via a reciprocal of 2^24 / 125.
  localparam logic [31:0] AmpSatMv    = 32'd500;
  localparam logic [9:0]  AmpMax      = 10'd1023;
  localparam logic [17:0] AmpRecip    = 18'd134217;
  localparam logic [16:0] AmpDiv      = 17'd125;

  typedef enum logic [1:0] {
    ActFreq  = 2'd0,
    ActAmp   = 2'd1,
    ActPhase = 2'd2
  } act_e;

  typedef enum logic {
    CfgFreqUpper = 1'b0,
    CfgFreqLower = 1'b1
  } cfg_reg_e;

  // Complete command as a byte frame, first byte in the top bits.
  typedef struct packed {
    logic [55:0] data;
    logic [2:0]  nbytes;
    logic        upd;
  } frame_t;

endpackage

@@ design/ddscf_calc.sv @@
// Five-stage arithmetic pipeline: clamp, tuning word and amplitude scaling, frame build.
module ddscf_calc import ddscf_pkg::*; #(
  parameter int unsigned REF_CLOCK_HZ = RefClockHz
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CfgW-1:0]  freq_upper_i,
  input  logic [CfgW-1:0]  freq_lower_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       action_i,
  input  logic [1:0]       channel_i,
  input  logic [ValW-1:0]  value_i,
  output logic             frm_valid_o,
  input  logic             frm_take_i,
  output frame_t           frm_o
);

  // Tuning word floor(f * 2^32 / R) from f * floor(2^61 / R) >> 29, off by at most one.
  localparam int unsigned   TwShift = 29;
  localparam logic [63:0]   TwMul   = (64'd1 << (32 + TwShift)) / 64'(REF_CLOCK_HZ);
  localparam int unsigned   MulW    = $clog2(TwMul + 64'd1);
  localparam int unsigned   LoW     = 21;
  localparam int unsigned   HiW     = MulW - LoW;
  localparam logic [LoW-1:0] MulLo  = TwMul[LoW-1:0];
  localparam logic [HiW-1:0] MulHi  = HiW'(TwMul >> LoW);
  localparam int unsigned   SumW    = FreqW + MulW + 1;
  localparam logic [29:0]   RefV    = 30'(REF_CLOCK_HZ);

  typedef struct packed {
    act_e             act;
    logic [1:0]       ch;
    logic [FreqW-1:0] f;
    logic             asat;
    logic [8:0]       mv;
    logic [15:0]      ph;
  } st_a_t;

  typedef struct packed {
    act_e                 act;
    logic [1:0]           ch;
    logic [FreqW-1:0]     f;
    logic                 fsat;
    logic [FreqW+LoW-1:0] pp_lo;
    logic [FreqW+HiW-1:0] pp_hi;
    logic                 asat;
    logic [8:0]           mv;
    logic [36:0]          pa;
    logic [15:0]          ph;
  } st_b_t;

  typedef struct packed {
    act_e             act;
    logic [1:0]       ch;
    logic [FreqW-1:0] f;
    logic             fsat;
    logic [31:0]      qe;
    logic             asat;
    logic [8:0]       mv;
    logic [9:0]       qa;
    logic [15:0]      ph;
  } st_c_t;

  typedef struct packed {
    act_e             act;
    logic [1:0]       ch;
    logic [FreqW-1:0] f;
    logic             fsat;
    logic [31:0]      qe;
    logic [61:0]      qr;
    logic [9:0]       amp;
    logic [15:0]      ph;
  } st_d_t;

  typedef struct packed {
    act_e        act;
    logic [1:0]  ch;
    logic [31:0] w;
  } st_e_t;

  logic [4:0] v_q, v_d;
  logic [4:0] rdy;
  st_a_t a_q, a_d;
  st_b_t b_q, b_d;
  st_c_t c_q, c_d;
  st_d_t d_q, d_d;
  st_e_t e_q, e_d;

  logic [FreqW-1:0] f_hi;
  logic [SumW-1:0]  tw_sum;
  logic [16:0]      ya_b, ya_d;
  logic [16:0]      qa_prod;
  logic [62:0]      cmp_lhs, cmp_rhs;
  logic [7:0]       mask;

  // Backpressure: a stage takes a new beat when empty or when its beat moves on.
  assign rdy[4] = !v_q[4] || frm_take_i;
  assign rdy[3] = !v_q[3] || rdy[4];
  assign rdy[2] = !v_q[2] || rdy[3];
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[0] = !v_q[0] || rdy[1];

  assign in_stall_o  = !rdy[0];
  assign frm_valid_o = v_q[4];

  always_comb begin
    // Drop unused action codes at the door.
    v_d[0] = in_valid_i && (action_i != 2'd3);
    v_d[1] = v_q[0];
    v_d[2] = v_q[1];
    v_d[3] = v_q[2];
    v_d[4] = v_q[3];
  end

  // Stage A: clamp, upper limit first, lower limit second.
  always_comb begin
    f_hi = (value_i > ValW'(freq_upper_i)) ? freq_upper_i : value_i[FreqW-1:0];
    a_d.act  = act_e'(action_i);
    a_d.ch   = channel_i;
    a_d.f    = (f_hi < freq_lower_i) ? freq_lower_i : f_hi;
    a_d.asat = value_i >= AmpSatMv;
    a_d.mv   = value_i[8:0];
    a_d.ph   = value_i[15:0];
  end

  // Stage B: partial products of the reciprocal multiplications.
  always_comb begin
    ya_b       = {a_q.mv, 8'b0};
    b_d.act    = a_q.act;
    b_d.ch     = a_q.ch;
    b_d.f      = a_q.f;
    b_d.fsat   = {1'b0, a_q.f} >= RefV;
    b_d.pp_lo  = (FreqW+LoW)'(a_q.f) * (FreqW+LoW)'(MulLo);
    b_d.pp_hi  = (FreqW+HiW)'(a_q.f) * (FreqW+HiW)'(MulHi);
    b_d.asat   = a_q.asat;
    b_d.mv     = a_q.mv;
    b_d.pa     = 37'(ya_b) * 37'(AmpRecip);
    b_d.ph     = a_q.ph;
  end

  // Stage C: combine partial products into the estimated quotients.
  always_comb begin
    tw_sum   = SumW'(b_q.pp_lo) + (SumW'(b_q.pp_hi) << LoW);
    c_d.act  = b_q.act;
    c_d.ch   = b_q.ch;
    c_d.f    = b_q.f;
    c_d.fsat = b_q.fsat;
    c_d.qe   = tw_sum[TwShift+31:TwShift];
    c_d.asat = b_q.asat;
    c_d.mv   = b_q.mv;
    c_d.qa   = b_q.pa[33:24];
    c_d.ph   = b_q.ph;
  end

  // Stage D: back-multiply the tuning word estimate, correct the amplitude.
  always_comb begin
    ya_d     = {c_q.mv, 8'b0};
    qa_prod  = 17'(c_q.qa) * AmpDiv;
    d_d.act  = c_q.act;
    d_d.ch   = c_q.ch;
    d_d.f    = c_q.f;
    d_d.fsat = c_q.fsat;
    d_d.qe   = c_q.qe;
    d_d.qr   = 62'(c_q.qe) * 62'(RefV);
    if (c_q.asat) begin
      d_d.amp = AmpMax;
    end else if ((ya_d - qa_prod) >= AmpDiv) begin
      d_d.amp = c_q.qa + 10'd1;
    end else begin
      d_d.amp = c_q.qa;
    end
    d_d.ph   = c_q.ph;
  end

  // Stage E: final tuning word correction and saturation, select payload word.
  always_comb begin
    cmp_lhs = 63'(d_q.qr) + 63'(RefV);
    cmp_rhs = {2'b0, d_q.f, 32'b0};
    e_d.act = d_q.act;
    e_d.ch  = d_q.ch;
    unique case (d_q.act)
      ActFreq: begin
        if (d_q.fsat) begin
          e_d.w = '1;
        end else begin
          e_d.w = d_q.qe + 32'(cmp_lhs <= cmp_rhs);
        end
      end
      ActAmp:   e_d.w = {8'h00, AmpEnable | {6'b0, d_q.amp[9:8]}, d_q.amp[7:0], 8'h00};
      ActPhase: e_d.w = {d_q.ph, 16'h0000};
      default:  e_d.w = '0;
    endcase
  end

  // Frame: channel select, data address, then the data bytes.
  always_comb begin
    mask = ChanMaskBase << e_q.ch;
    unique case (e_q.act)
      ActFreq: begin
        frm_o.data   = {AddrChanSel, mask, AddrFreq, e_q.w};
        frm_o.nbytes = 3'd7;
        frm_o.upd    = 1'b1;
      end
      ActAmp: begin
        frm_o.data   = {AddrChanSel, mask, AddrAmp, e_q.w};
        frm_o.nbytes = 3'd6;
        frm_o.upd    = 1'b1;
      end
      ActPhase: begin
        frm_o.data   = {AddrChanSel, mask, AddrPhase, e_q.w};
        frm_o.nbytes = 3'd5;
        frm_o.upd    = 1'b0;
      end
      default: begin
        frm_o.data   = '0;
        frm_o.nbytes = 3'd0;
        frm_o.upd    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < 5; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      a_q <= a_d;
    end
    if (rdy[1]) begin
      b_q <= b_d;
    end
    if (rdy[2]) begin
      c_q <= c_d;
    end
    if (rdy[3]) begin
      d_q <= d_d;
    end
    if (rdy[4]) begin
      e_q <= e_d;
    end
  end

endmodule

@@ design/dds_channel_command_framer_top.sv @@
// Top level: limit registers, arithmetic pipeline, byte serialiser and output register.
//
//   channel   direction  handshake               payload
//   command   in         in_valid_i / in_stall_o  action_i, channel_i, value_i
//   bytes     out        out_valid_o / out_stall_i spi_byte_o, frame_end_o,
//                                                 update_pulse_o, last_o
//   config    in         cfg_we_i                 cfg_idx_i, cfg_data_i
//
// A command passes five pipeline stages before its bytes start. The
// serialiser sends one byte a cycle while the byte side does not stall,
// so a command occupies it for 7 (frequency), 6 (amplitude) or 5 (phase)
// bytes, which sets the sustained rate. Action code 3 is taken and
// dropped. Reset clears all valid bits and loads the limit registers.
// A stall on the byte side holds the output beat and backs up the pipeline.
module dds_channel_command_framer_top import ddscf_pkg::*; #(
  parameter int unsigned REF_CLOCK_HZ = RefClockHz
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      action_i,
  input  logic [1:0]      channel_i,
  input  logic [ValW-1:0] value_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      spi_byte_o,
  output logic            frame_end_o,
  output logic            update_pulse_o,
  output logic            last_o
);

  logic [CfgW-1:0] upper_q, lower_q;
  logic            frm_valid, frm_take;
  frame_t          frm;

  logic [55:0] sh_q, sh_d;
  logic [2:0]  rem_q, rem_d;
  logic [2:0]  idx_q, idx_d;
  logic        upd_q, upd_d;
  logic        emit, out_free, fend;

  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic        ofe_q, ofe_d;
  logic        oup_q, oup_d;
  logic        olast_q, olast_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= FreqUpperReset;
      lower_q <= FreqLowerReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgFreqUpper: upper_q <= cfg_data_i;
        CfgFreqLower: lower_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ddscf_calc #(
    .REF_CLOCK_HZ(REF_CLOCK_HZ)
  ) u_calc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .freq_upper_i (upper_q),
    .freq_lower_i (lower_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .channel_i    (channel_i),
    .value_i      (value_i),
    .frm_valid_o  (frm_valid),
    .frm_take_i   (frm_take),
    .frm_o        (frm)
  );

  assign out_free = !ov_q || !out_stall_i;
  assign emit     = (rem_q != 3'd0) && out_free;
  // Take the next frame when idle or while sending the final byte.
  assign frm_take = (rem_q == 3'd0) || (emit && (rem_q == 3'd1));
  assign fend     = (idx_q == 3'd1) || (rem_q == 3'd1);

  always_comb begin
    sh_d  = sh_q;
    rem_d = rem_q;
    idx_d = idx_q;
    upd_d = upd_q;
    if (frm_take && frm_valid) begin
      sh_d  = frm.data;
      rem_d = frm.nbytes;
      idx_d = 3'd0;
      upd_d = frm.upd;
    end else if (emit) begin
      sh_d  = {sh_q[47:0], 8'h00};
      rem_d = rem_q - 3'd1;
      idx_d = idx_q + 3'd1;
    end
  end

  always_comb begin
    ov_d    = ov_q;
    ob_d    = ob_q;
    ofe_d   = ofe_q;
    oup_d   = oup_q;
    olast_d = olast_q;
    if (out_free) begin
      ov_d    = emit;
      ob_d    = sh_q[55:48];
      ofe_d   = fend;
      oup_d   = fend && upd_q;
      olast_d = rem_q == 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
      idx_q <= 3'd0;
      ov_q  <= 1'b0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q    <= sh_d;
    upd_q   <= upd_d;
    ob_q    <= ob_d;
    ofe_q   <= ofe_d;
    oup_q   <= oup_d;
    olast_q <= olast_d;
  end

  assign out_valid_o    = ov_q;
  assign spi_byte_o     = ob_q;
  assign frame_end_o    = ofe_q;
  assign update_pulse_o = oup_q;
  assign last_o         = olast_q;

endmodule

@@ tb/ddscf_checker.sv @@
// Scoreboard for the channel command framer: predicts each command's bytes and checks them.
`timescale 1ns / 1ps

module ddscf_checker import ddscf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic [1:0]      action_i,
  input  logic [1:0]      channel_i,
  input  logic [ValW-1:0] value_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  logic [7:0]      spi_byte_i,
  input  logic            frame_end_i,
  input  logic            update_pulse_i,
  input  logic            last_i,
  output int unsigned     err_count_o,
  output int unsigned     pending_o
);

  localparam logic [63:0] AmpScale   = 64'd1024;
  localparam logic [63:0] AmpRefMv   = 64'd500;
  localparam logic [63:0] AmpCeil    = 64'd1023;
  localparam logic [15:0] AmpEnBit   = 16'h1000;
  localparam logic [63:0] TuneWordMax = 64'hFFFF_FFFF;

  typedef struct {
    logic [7:0] data;
    logic       frame_end;
    logic       update_pulse;
    logic       last;
  } spi_beat_t;

  spi_beat_t       spi_bytes_q[$];
  logic [CfgW-1:0] upper_hz;
  logic [CfgW-1:0] lower_hz;

  function automatic void put_beat(logic [7:0] data, logic fend, logic upd, logic fin);
    spi_beat_t b;
    b.data         = data;
    b.frame_end    = fend;
    b.update_pulse = fend & upd;
    b.last         = fin;
    spi_bytes_q.push_back(b);
  endfunction

  function automatic logic [31:0] tuning_word_of(logic [31:0] hz);
    logic [31:0] f;
    logic [63:0] tw;
    f = hz;
    // upper clamp first, so a lower limit above the upper one wins
    if (f > 32'(upper_hz)) f = 32'(upper_hz);
    if (f < 32'(lower_hz)) f = 32'(lower_hz);
    tw = (64'(f) << 32) / 64'(RefClockHz);
    if (tw > TuneWordMax) tw = TuneWordMax;
    return tw[31:0];
  endfunction

  function automatic logic [15:0] amplitude_word_of(logic [31:0] mv);
    logic [63:0] a;
    a = (64'(mv) * AmpScale) / AmpRefMv;
    if (a > AmpCeil) a = AmpCeil;
    return a[15:0] | AmpEnBit;
  endfunction

  function automatic void frame_command(logic [1:0] act, logic [1:0] ch, logic [31:0] val);
    logic        upd;
    logic [31:0] w;
    logic [15:0] a;
    upd = (act != ActPhase);
    if (act != ActFreq && act != ActAmp && act != ActPhase) return;
    put_beat(AddrChanSel, 1'b0, upd, 1'b0);
    put_beat(ChanMaskBase << ch, 1'b1, upd, 1'b0);
    case (act)
      ActFreq: begin
        w = tuning_word_of(val);
        put_beat(AddrFreq, 1'b0, upd, 1'b0);
        put_beat(w[31:24], 1'b0, upd, 1'b0);
        put_beat(w[23:16], 1'b0, upd, 1'b0);
        put_beat(w[15:8], 1'b0, upd, 1'b0);
        put_beat(w[7:0], 1'b1, upd, 1'b1);
      end
      ActAmp: begin
        a = amplitude_word_of(val);
        put_beat(AddrAmp, 1'b0, upd, 1'b0);
        put_beat(8'h00, 1'b0, upd, 1'b0);
        put_beat(a[15:8], 1'b0, upd, 1'b0);
        put_beat(a[7:0], 1'b1, upd, 1'b1);
      end
      default: begin
        put_beat(AddrPhase, 1'b0, upd, 1'b0);
        put_beat(val[15:8], 1'b0, upd, 1'b0);
        put_beat(val[7:0], 1'b1, upd, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    spi_beat_t exp_b;
    if (!rst_ni) begin
      upper_hz = FreqUpperReset;
      lower_hz = FreqLowerReset;
      spi_bytes_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (spi_bytes_q.size() == 0) begin
          $error("unexpected byte beat: spi_byte %h", spi_byte_i);
          err_count_o++;
        end else begin
          exp_b = spi_bytes_q.pop_front();
          if (spi_byte_i !== exp_b.data) begin
            $error("spi_byte: expected %h, got %h", exp_b.data, spi_byte_i);
            err_count_o++;
          end
          if (frame_end_i !== exp_b.frame_end) begin
            $error("frame_end: expected %b, got %b", exp_b.frame_end, frame_end_i);
            err_count_o++;
          end
          if (update_pulse_i !== exp_b.update_pulse) begin
            $error("update_pulse: expected %b, got %b", exp_b.update_pulse, update_pulse_i);
            err_count_o++;
          end
          if (last_i !== exp_b.last) begin
            $error("last: expected %b, got %b", exp_b.last, last_i);
            err_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) frame_command(action_i, channel_i, value_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgFreqUpper: upper_hz = cfg_data_i;
          CfgFreqLower: lower_hz = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = spi_bytes_q.size();
  end

endmodule

@@ tb/tb_dds_channel_command_framer_top.sv @@
// Testbench top: clock, reset, command and limit stimulus, byte-side stalls and the verdict.
`timescale 1ns / 1ps

module tb_dds_channel_command_framer_top;
  import ddscf_pkg::*;

  localparam logic [1:0]  ActUnused     = 2'd3;
  localparam int unsigned LongHold      = 150;
  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned WatchdogLimit = 2000;
  localparam logic [CfgW-1:0] LimitMax  = 29'h1FFF_FFFF;

  logic            clk_i;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic            cfg_idx_i   = CfgFreqUpper;
  logic [CfgW-1:0] cfg_data_i  = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  logic [1:0]      action_i    = ActFreq;
  logic [1:0]      channel_i   = 2'd0;
  logic [ValW-1:0] value_i     = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [7:0]      spi_byte_o;
  logic            frame_end_o;
  logic            update_pulse_o;
  logic            last_o;

  int unsigned     err_count;
  int unsigned     bytes_pending;

  int unsigned     gap_pct   = 0;
  int unsigned     stall_pct = 0;
  bit              hold_req  = 1'b0;
  logic [CfgW-1:0] cur_upper = FreqUpperReset;
  logic [CfgW-1:0] cur_lower = FreqLowerReset;

  dds_channel_command_framer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .channel_i      (channel_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .spi_byte_o     (spi_byte_o),
    .frame_end_o    (frame_end_o),
    .update_pulse_o (update_pulse_o),
    .last_o         (last_o)
  );

  ddscf_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .action_i       (action_i),
    .channel_i      (channel_i),
    .value_i        (value_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .spi_byte_i     (spi_byte_o),
    .frame_end_i    (frame_end_o),
    .update_pulse_i (update_pulse_o),
    .last_i         (last_o),
    .err_count_o    (err_count),
    .pending_o      (bytes_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one command, optionally after a gap, and hold it until it is taken.
  task automatic send_cmd(input logic [1:0] act, input logic [1:0] ch, input logic [31:0] val);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    channel_i  <= ch;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_random_cmd();
    logic [1:0]  act;
    logic [31:0] val;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) act = ActUnused;
    else if (pick < 50) act = ActFreq;
    else if (pick < 75) act = ActAmp;
    else act = ActPhase;
    case (act)
      ActFreq: begin
        case ($urandom_range(0, 3))
          0: val = $urandom();
          1: val = $urandom_range(0, 600000000);
          2: val = 32'(cur_upper) + $urandom_range(0, 4) - 2;
          default: val = 32'(cur_lower) + $urandom_range(0, 4) - 2;
        endcase
      end
      ActAmp: val = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 600);
      default: val = $urandom();
    endcase
    send_cmd(act, 2'($urandom_range(0, 3)), val);
  endtask

  // Drop valid, let every expected beat arrive, then allow for a dropped command in flight.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (bytes_pending == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [CfgW-1:0] upper, input logic [CfgW-1:0] lower);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgFreqUpper;
    cfg_data_i <= upper;
    @(posedge clk_i);
    cfg_idx_i  <= CfgFreqLower;
    cfg_data_i <= lower;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_upper = upper;
    cur_lower = lower;
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_random_cmd();
  endtask

  // Byte side: random stall bursts, or one long hold on request.
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset limits: field extremes, every channel and action, dropped code
    gap_pct   = 30;
    stall_pct = 30;
    send_cmd(ActFreq, 2'd0, 32'd0);
    send_cmd(ActFreq, 2'd1, 32'd1);
    send_cmd(ActFreq, 2'd2, 32'd200000000);
    send_cmd(ActFreq, 2'd3, 32'd200000001);
    send_cmd(ActFreq, 2'd3, 32'hFFFF_FFFF);
    send_cmd(ActFreq, 2'd0, 32'd123456789);
    send_cmd(ActAmp, 2'd0, 32'd0);
    send_cmd(ActAmp, 2'd1, 32'd499);
    send_cmd(ActAmp, 2'd2, 32'd500);
    send_cmd(ActAmp, 2'd3, 32'd501);
    send_cmd(ActAmp, 2'd0, 32'hFFFF_FFFF);
    send_cmd(ActAmp, 2'd1, 32'd250);
    send_cmd(ActAmp, 2'd2, 32'h8000_0000);
    send_cmd(ActUnused, 2'd3, 32'hFFFF_FFFF);
    send_cmd(ActPhase, 2'd0, 32'h0000_0000);
    send_cmd(ActPhase, 2'd1, 32'hFFFF_0000);
    send_cmd(ActPhase, 2'd2, 32'h0000_FFFF);
    send_cmd(ActPhase, 2'd3, 32'hFFFF_FFFF);
    send_cmd(ActUnused, 2'd0, 32'h0000_0000);
    send_cmd(ActPhase, 2'd0, 32'h1234_5678);
    drain();

    // Widest limits: tuning word saturation at and above the reference clock
    set_limits(LimitMax, '0);
    send_cmd(ActFreq, 2'd1, 32'hFFFF_FFFF);
    send_cmd(ActFreq, 2'd2, 32'd500000000);
    send_cmd(ActFreq, 2'd3, 32'd499999999);
    send_cmd(ActFreq, 2'd0, 32'd536870911);
    run_random(30);
    drain();

    // Crossed limits, with the byte side held off until the block backs up
    set_limits(29'd1000, 29'd300000000);
    hold_req = 1'b1;
    run_random(25);
    drain();

    set_limits('0, '0);
    gap_pct   = 10;
    stall_pct = 50;
    run_random(15);
    drain();

    set_limits(29'($urandom_range(0, 500000000)), 29'($urandom_range(0, 500000000)));
    gap_pct   = 40;
    stall_pct = 15;
    run_random(30);
    drain();

    // Full throughput: no idling on either side
    set_limits(29'd500000000, 29'd1);
    gap_pct   = 0;
    stall_pct = 0;
    run_random(40);
    drain();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ddscf_pkg.sv
design/ddscf_calc.sv
design/dds_channel_command_framer_top.sv
tb/ddscf_checker.sv
tb/tb_dds_channel_command_framer_top.sv
